/* rtl/bei_pkg.sv */
`timescale 1ns / 1ps
package bei_pkg;
  localparam int unsigned MaxPoints = 64;
  localparam int unsigned IdxW = $clog2(MaxPoints);
  localparam int unsigned CntW = $clog2(MaxPoints + 1);
  localparam int unsigned TickW = 32;
  localparam int unsigned LevelW = 24;
  localparam int unsigned EntryW = TickW + LevelW;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StEmpty    = 3'd1;
  localparam logic [2:0] StInserted = 3'd2;
  localparam logic [2:0] StReplaced = 3'd3;
  localparam logic [2:0] StFull     = 3'd4;

  localparam logic OpInsert = 1'b0;
  localparam logic OpQuery  = 1'b1;

  typedef struct packed {
    logic                     op;
    logic [TickW-1:0]         tick;
    logic signed [LevelW-1:0] level;
  } bei_in_t;

  typedef struct packed {
    logic signed [LevelW-1:0] envelope;
    logic [2:0]               status;
  } bei_out_t;
endpackage

/* rtl/bei_ram.sv */
`timescale 1ns / 1ps
module bei_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* rtl/bei_div.sv */
`timescale 1ns / 1ps
// Restoring divider, unsigned 57/32 bit, one quotient bit a cycle.
module bei_div
  import bei_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [56:0]      dividend_i,
  input  logic [TickW-1:0] divisor_i,
  output logic             done_o,
  output logic [56:0]      quot_o
);
  logic [56:0] quot_q, quot_d;
  logic [32:0] rem_q, rem_d;
  logic [TickW-1:0] dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [33:0] trial;
  logic [32:0] shifted;

  assign shifted = {rem_q[31:0], quot_q[56]};
  assign trial   = {1'b0, shifted} - {2'b0, dvs_q};

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = 6'd56;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[33]) begin
        rem_d  = trial[32:0];
        quot_d = {quot_q[55:0], 1'b1};
      end else begin
        rem_d  = shifted;
        quot_d = {quot_q[55:0], 1'b0};
      end
      if (cnt_q == '0) busy_d = 1'b0;
      else cnt_d = cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign quot_o = {quot_d};
endmodule

/* rtl/breakpoint_envelope_interpolator_core.sv */
`timescale 1ns / 1ps
// Breakpoint envelope interpolator.
// Input channel (in_valid_i / in_stall_o / in_data_i): an insert adds or
// replaces a breakpoint (tick, level); a query returns the level at a tick,
// clamped at the table ends and linearly interpolated in between.
// Output channel (out_valid_o / out_stall_i / out_data_o): one item per input
// item carrying envelope (Q3.20) and status.
// The table sits in one synchronous RAM of tick/level pairs, read one entry
// a cycle. An item first scans from entry 0 until tick >= input tick or the
// end of the table. An insert of a new tick then shifts the tail up one
// entry at a time, reading each in SShRd and writing it one place up in
// SShWr. A query inside the table forms the product in SPrev, then runs a
// serial divide (started in SMul, awaited in SDiv). The scan loop and the
// single RAM port dominate the worst case. One item is in work at a time.
// Reset empties the table (count to zero); entry contents need no clearing.
// The result waits in an output register while out_stall_i is high; the next
// item is taken only after that register has been emptied.
module breakpoint_envelope_interpolator_core
  import bei_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  bei_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output bei_out_t out_data_o
);
  typedef enum logic [7:0] {
    SIdle  = 8'b0000_0001,
    SScan  = 8'b0000_0010,
    SShRd  = 8'b0000_0100,
    SShWr  = 8'b0000_1000,
    SPrev  = 8'b0001_0000,
    SMul   = 8'b0010_0000,
    SDiv   = 8'b0100_0000,
    SOut   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  bei_in_t item_q, item_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] raddr;
  logic            we;
  logic [IdxW-1:0] waddr;
  logic [EntryW-1:0] wdata, rdata;
  logic [EntryW-1:0] hold_q, hold_d;   // upper breakpoint or shifted entry
  logic              rd_pend_q, rd_pend_d;
  bei_out_t res_q, res_d;
  logic     out_valid_q, out_valid_d;
  logic signed [56:0] prod_q, prod_d;
  logic signed [LevelW-1:0] y0_q, y0_d;
  logic [TickW-1:0] span_q, span_d;
  logic       div_start;
  logic       div_done;
  logic [56:0] quot;
  logic [TickW-1:0] rtick;
  logic signed [LevelW-1:0] rlevel;
  logic [TickW-1:0] htick;
  logic signed [LevelW-1:0] hlevel;
  logic signed [56:0] qs;
  logic signed [LevelW:0] dy;

  assign rtick  = rdata[EntryW-1 -: TickW];
  assign rlevel = rdata[LevelW-1:0];
  assign htick  = hold_q[EntryW-1 -: TickW];
  assign hlevel = hold_q[LevelW-1:0];
  assign dy     = {rlevel[LevelW-1], rlevel};

  bei_ram #(.Width(EntryW), .Depth(MaxPoints)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  bei_div u_div (
    .clk_i, .rst_ni, .start_i(div_start),
    .dividend_i(prod_q[56] ? 57'(-prod_q) : 57'(prod_q)),
    .divisor_i(span_q), .done_o(div_done), .quot_o(quot)
  );

  assign qs = prod_q[56] ? -$signed(quot) : $signed(quot);

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    hold_d      = hold_q;
    rd_pend_d   = 1'b0;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    prod_d      = prod_q;
    y0_d        = y0_q;
    span_d      = span_q;
    raddr       = idx_q[IdxW-1:0];
    we          = 1'b0;
    waddr       = idx_q[IdxW-1:0];
    wdata       = {item_q.tick, item_q.level};
    div_start   = 1'b0;
    in_stall_o  = 1'b1;

    unique case (state_q)
      SIdle: begin
        in_stall_o = out_valid_q;
        if (in_valid_i && !out_valid_q) begin
          item_d    = in_data_i;
          idx_d     = '0;
          raddr     = '0;
          rd_pend_d = 1'b1;
          state_d   = SScan;
        end
      end
      // Advance through the table one entry a cycle until tick >= target.
      SScan: begin
        if (!rd_pend_q) begin
          rd_pend_d = 1'b1;
        end else if (idx_q < cnt_q && rtick < item_q.tick) begin
          idx_d     = idx_q + 1'b1;
          raddr     = IdxW'(idx_q + 1'b1);
          rd_pend_d = 1'b1;
        end else if (item_q.op == OpInsert) begin
          if (idx_q < cnt_q && rtick == item_q.tick) begin
            we      = 1'b1;
            res_d   = '{envelope: '0, status: StReplaced};
            state_d = SOut;
          end else if (cnt_q >= CntW'(MaxPoints)) begin
            res_d   = '{envelope: '0, status: StFull};
            state_d = SOut;
          end else begin
            hold_d  = {item_q.tick, item_q.level};
            state_d = SShRd;
          end
        end else begin
          if (cnt_q == '0) begin
            res_d   = '{envelope: '0, status: StEmpty};
            state_d = SOut;
          end else if (idx_q == '0) begin
            res_d   = '{envelope: rlevel, status: StOk};
            state_d = SOut;
          end else if (idx_q == cnt_q) begin
            // past the end: fetch the last entry
            idx_d     = idx_q - 1'b1;
            raddr     = IdxW'(idx_q - 1'b1);
            rd_pend_d = 1'b1;
            state_d   = SPrev;
          end else if (rtick == item_q.tick) begin
            res_d   = '{envelope: rlevel, status: StOk};
            state_d = SOut;
          end else begin
            hold_d    = rdata;
            idx_d     = idx_q - 1'b1;
            raddr     = IdxW'(idx_q - 1'b1);
            rd_pend_d = 1'b1;
            state_d   = SPrev;
          end
        end
      end
      // Insert: read entry idx, write carried entry there, carry old on.
      SShRd: begin
        state_d = SShWr;
      end
      SShWr: begin
        we    = 1'b1;
        wdata = hold_q;
        hold_d = rdata;
        if (idx_q == cnt_q) begin
          cnt_d   = cnt_q + 1'b1;
          res_d   = '{envelope: '0, status: StInserted};
          state_d = SOut;
        end else begin
          idx_d   = idx_q + 1'b1;
          raddr   = IdxW'(idx_q + 1'b1);
          state_d = SShRd;
        end
      end
      SPrev: begin
        if (!rd_pend_q) begin
          if (idx_q == cnt_q - 1'b1) begin
            res_d   = '{envelope: rlevel, status: StOk};
            state_d = SOut;
          end else begin
            y0_d   = rlevel;
            span_d = htick - rtick;
            prod_d = 57'($signed({1'b0, item_q.tick - rtick})
                     * ($signed({hlevel[LevelW-1], hlevel}) - dy));
            state_d = SMul;
          end
        end
      end
      SMul: begin
        div_start = 1'b1;
        state_d   = SDiv;
      end
      SDiv: begin
        if (div_done) begin
          res_d   = '{envelope: LevelW'(qs + 57'(y0_q)), status: StOk};
          state_d = SOut;
        end
      end
      SOut: begin
        out_valid_d = 1'b1;
        state_d     = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      cnt_q       <= '0;
      idx_q       <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    hold_q <= hold_d;
    res_q  <= res_d;
    prod_q <= prod_d;
    y0_q   <= y0_d;
    span_q <= span_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;
endmodule
